[rtl/lru_page_replacement_macros.svh]
// Assertion macros shared by the LRU page replacement RTL.
// Included by every module that carries concurrent checks; needs clk_i and rst_ni in scope.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define LRUPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lru_page_replacement: check failed");
// Checks that a condition in the next cycle follows from the present one.
`define LRUPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lru_page_replacement: check failed");
`else
`define LRUPR_ASSERT(lbl, prop)
`define LRUPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/lrupr_pkg.sv]
// Shared constants and types for the LRU page replacement block.
// Used by lrupr_cell and lru_page_replacement; depends on nothing else.
package lrupr_pkg;

  // Sizing of the frame row.
  localparam int unsigned NUM_FRAMES   = 4;
  localparam int unsigned PAGE_BITS    = 16;
  localparam int unsigned IDX_W        = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned RANK_W       = IDX_W;

  // Field widths of the stream beats.
  localparam int unsigned PAGE_FIELD_W = 16;
  localparam int unsigned PAGE_W       = (PAGE_BITS < PAGE_FIELD_W) ? PAGE_BITS : PAGE_FIELD_W;
  localparam int unsigned SLOT_W       = 2;
  localparam int unsigned FAULT_W      = 32;
  localparam int unsigned IN_TDATA_W   = ((PAGE_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_W  = SLOT_W + FAULT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic              fire;      // a reference is taken this cycle
    logic              miss;      // no cell holds the page
    logic [RANK_W-1:0] sel_rank;  // rank of the chosen cell before the update
    logic [PAGE_W-1:0] page;      // masked page number
  } cell_cmd_t;

  // Status reported by each cell to the top level.
  typedef struct packed {
    logic              hit;       // first cell holding the page
    logic              empty;     // first cell without a page
    logic              victim;    // valid cell of the oldest rank
    logic [RANK_W-1:0] rank;
  } cell_stat_t;

endpackage

[rtl/lrupr_cell.sv]
// One frame of the LRU row: page tag, valid bit and recency rank.
// Depends on lrupr_pkg and lru_page_replacement_macros.svh.
`include "lru_page_replacement_macros.svh"

module lrupr_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lrupr_pkg::cell_cmd_t  cmd_i,
  input  logic                  sel_i,
  input  logic                  hit_before_i,
  input  logic                  empty_before_i,
  output logic                  hit_before_o,
  output logic                  empty_before_o,
  output lrupr_pkg::cell_stat_t stat_o
);
  import lrupr_pkg::*;

  logic [PAGE_W-1:0] page_q, page_d;
  logic              valid_q, valid_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic              match;

  // Tag compare and the priority chains handed along the row.
  assign match          = valid_q && (page_q == cmd_i.page);
  assign hit_before_o   = hit_before_i | match;
  assign empty_before_o = empty_before_i | !valid_q;

  assign stat_o.hit    = match && !hit_before_i;
  assign stat_o.empty  = !valid_q && !empty_before_i;
  assign stat_o.victim = valid_q && (rank_q == RANK_W'(NUM_FRAMES - 1));
  assign stat_o.rank   = rank_q;

  // The chosen frame becomes newest; other valid frames age by one, on a hit only those younger.
  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    rank_d  = rank_q;
    if (cmd_i.fire) begin
      if (sel_i) begin
        rank_d = '0;
        if (cmd_i.miss) begin
          valid_d = 1'b1;
          page_d  = cmd_i.page;
        end
      end else if (valid_q && (cmd_i.miss || (rank_q < cmd_i.sel_rank))) begin
        rank_d = rank_q + RANK_W'(1);
      end
    end
  end

  // Control state is reset; the tag is only read while the frame is valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  // An empty frame always sits at rank zero, and a filled frame stays filled.
  `LRUPR_ASSERT(a_empty_rank_zero, !valid_q |-> (rank_q == '0))
  `LRUPR_ASSERT_NEXT(a_valid_sticks, valid_q, valid_q)

endmodule

[rtl/lru_page_replacement.sv]
// Top level of the LRU page replacement block: row of frame cells and result register.
// Depends on lrupr_pkg, lrupr_cell and lru_page_replacement_macros.svh.
//
// Each page reference beat on the slave side produces exactly one result beat on the master
// side in the cycle after it is taken, and a new reference is taken in every cycle while
// the result register is empty or being drained, so the sustained rate is one reference per
// cycle. That figure is set by the row of frame cells, which compare the page against every
// frame, choose the hit, the first empty frame or the oldest frame, and update all ranks in
// the same cycle. After reset all frames are empty and the fault count is zero; no clearing
// pass is needed.
`include "lru_page_replacement_macros.svh"

module lru_page_replacement (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Slave side: tdata = page[15:0].
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [lrupr_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // Master side: tdata = slot[1:0], fault_count[33:2], zero padding above.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [lrupr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // Master side: tuser = hit.
  output logic                               m_axis_tuser_o
);
  import lrupr_pkg::*;

  cell_cmd_t                   cmd;
  cell_stat_t [NUM_FRAMES-1:0] stat;
  logic [NUM_FRAMES:0]         hit_chain;
  logic [NUM_FRAMES:0]         empty_chain;
  logic [NUM_FRAMES-1:0]       sel;
  logic [IDX_W-1:0]            sel_idx;
  logic [RANK_W-1:0]           sel_rank;
  logic [PAGE_FIELD_W-1:0]     page_field;
  logic                        any_hit;
  logic                        any_empty;
  logic                        fire;

  logic [FAULT_W-1:0]          faults_q, faults_d;
  logic                        out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]      out_data_q, out_data_d;
  logic                        out_hit_q, out_hit_d;

  // A beat is taken whenever the result register is free or being emptied.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign fire            = s_axis_tvalid_i && s_axis_tready_o;
  assign page_field      = s_axis_tdata_i[PAGE_FIELD_W-1:0];

  // Row of frame cells, chained for first-match and first-empty priority.
  assign hit_chain[0]   = 1'b0;
  assign empty_chain[0] = 1'b0;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    lrupr_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .sel_i          (sel[g]),
      .hit_before_i   (hit_chain[g]),
      .empty_before_i (empty_chain[g]),
      .hit_before_o   (hit_chain[g+1]),
      .empty_before_o (empty_chain[g+1]),
      .stat_o         (stat[g])
    );
  end

  assign any_hit   = hit_chain[NUM_FRAMES];
  assign any_empty = empty_chain[NUM_FRAMES];

  // Choose the frame: the hit, else the first empty frame, else the oldest frame.
  always_comb begin
    sel_idx  = '0;
    sel_rank = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (any_hit) begin
        sel[i] = stat[i].hit;
      end else if (any_empty) begin
        sel[i] = stat[i].empty;
      end else begin
        sel[i] = stat[i].victim;
      end
      if (sel[i]) begin
        sel_idx  = sel_idx | IDX_W'(i);
        sel_rank = sel_rank | stat[i].rank;
      end
    end
  end

  assign cmd.fire     = fire;
  assign cmd.miss     = !any_hit;
  assign cmd.sel_rank = sel_rank;
  assign cmd.page     = page_field[PAGE_W-1:0];

  // Saturating fault count and the result register.
  always_comb begin
    faults_d    = faults_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_hit_d   = out_hit_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      if (!any_hit && (faults_q != '1)) begin
        faults_d = faults_q + FAULT_W'(1);
      end
      out_valid_d = 1'b1;
      out_hit_d   = any_hit;
      out_data_d  = OUT_TDATA_W'({faults_d, SLOT_W'(sel_idx)});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      faults_q    <= faults_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_hit_q  <= out_hit_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_hit_q;

  // Exactly one frame is chosen per reference, and hits leave the fault count alone.
  `LRUPR_ASSERT(a_one_frame_chosen, fire |-> $onehot(sel))
  `LRUPR_ASSERT_NEXT(a_hit_keeps_count, fire && any_hit, faults_q == $past(faults_q))
  `LRUPR_ASSERT(a_count_monotonic, faults_q >= $past(faults_q))

endmodule

[test/lru_page_replacement_tb.sv]
// Self-checking testbench for the LRU page replacement block, driving page reference beats.
// It depends on lrupr_pkg and the lru_page_replacement RTL; it uses no other file.
`timescale 1ns / 1ps

module lru_page_replacement_tb;
  import lrupr_pkg::*;

  localparam int unsigned CLK_PERIOD = 20;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned CHUNKS = 10;
  localparam int unsigned CHUNK_ITEMS = 95;
  localparam int unsigned REPORT_LIMIT = 10;

  // One result beat split into its fields.
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [FAULT_W-1:0] faults;
  } lru_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // Slave side tdata: page[15:0].
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // Master side tdata: slot[1:0], fault_count[33:2], zero padding above.
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  // Master side tuser: hit.
  logic                   m_axis_tuser_o;

  lru_page_replacement i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Pages waiting to be offered and results waiting to arrive.
  logic [PAGE_FIELD_W-1:0] pending_pages[$];
  lru_result_t             expected_results[$];
  int unsigned             error_count = 0;

  // Shared pacing controls, written by the stimulus process only.
  bit idle_on = 1'b0;
  bit long_hold_go = 1'b0;

  // Mirror of the frame row.
  logic [PAGE_W-1:0] frame_pg  [NUM_FRAMES];
  bit                frame_vld [NUM_FRAMES] = '{default: 1'b0};
  int unsigned       frame_age [NUM_FRAMES] = '{default: 0};
  logic [FAULT_W-1:0] miss_total = '0;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Applies one page reference to the mirror and queues the result it must give.
  task automatic track_reference(input logic [PAGE_FIELD_W-1:0] raw);
    logic [PAGE_W-1:0] pg;
    int                sel;
    int unsigned       limit;
    lru_result_t       res;
    pg  = raw[PAGE_W-1:0];
    sel = -1;
    for (int i = 0; i < NUM_FRAMES; i++)
      if (sel < 0 && frame_vld[i] && frame_pg[i] == pg) sel = i;
    if (sel >= 0) begin
      // A hit only ages the frames younger than the one hit.
      res.hit = 1'b1;
      limit   = frame_age[sel];
    end else begin
      res.hit = 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++)
        if (sel < 0 && !frame_vld[i]) sel = i;
      // With every frame full the oldest goes, the lowest index on a tie.
      if (sel < 0) begin
        sel = 0;
        for (int i = 1; i < NUM_FRAMES; i++)
          if (frame_age[i] > frame_age[sel]) sel = i;
      end
      limit          = 32'hFFFF_FFFF;
      frame_vld[sel] = 1'b1;
      frame_pg[sel]  = pg;
      if (miss_total != '1) miss_total = miss_total + 1'b1;
    end
    for (int i = 0; i < NUM_FRAMES; i++)
      if (i != sel && frame_vld[i] && frame_age[i] < limit) frame_age[i]++;
    frame_age[sel] = 0;
    res.slot   = sel[SLOT_W-1:0];
    res.faults = miss_total;
    expected_results.push_back(res);
  endtask

  // Compares a result beat with the oldest expectation.
  task automatic check_result();
    lru_result_t got;
    lru_result_t want;
    got.hit    = m_axis_tuser_o;
    got.slot   = m_axis_tdata_o[SLOT_W-1:0];
    got.faults = m_axis_tdata_o[SLOT_W +: FAULT_W];
    if (expected_results.size() == 0) begin
      if (error_count < REPORT_LIMIT)
        $display("%0t: unexpected result beat hit=%0b slot=%0d faults=%0d",
                 $realtime, got.hit, got.slot, got.faults);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.hit !== want.hit || got.slot !== want.slot || got.faults !== want.faults) begin
        if (error_count < REPORT_LIMIT)
          $display("%0t: mismatch expected hit=%0b slot=%0d faults=%0d, %s%0b %s%0d %s%0d",
                   $realtime, want.hit, want.slot, want.faults,
                   "got hit=", got.hit, "slot=", got.slot, "faults=", got.faults);
        error_count++;
      end
    end
  endtask

  // Driver: offers queued pages, holding each beat until it is taken.
  int unsigned src_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      src_gap         <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) track_reference(s_axis_tdata_i[PAGE_FIELD_W-1:0]);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (src_gap != 0) begin
          src_gap         <= src_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_pages.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_pages.pop_front();
          src_gap         <= idle_on ? pick_gap() : 0;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result beats and paces tready, with one long hold-off on request.
  int unsigned sink_stall = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    int unsigned g;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_stall      <= 0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_result();
      if (long_hold_go && !hold_done) begin
        hold_done       <= 1'b1;
        hold_left       <= LONG_HOLD - 1;
        m_axis_tready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left       <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (sink_stall != 0) begin
        sink_stall      <= sink_stall - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        g = idle_on ? pick_gap() : 0;
        if (g == 0) begin
          m_axis_tready_i <= 1'b1;
        end else begin
          m_axis_tready_i <= 1'b0;
          sink_stall      <= g - 1;
        end
      end
    end
  end

  // Waits until the driver is empty and every expected result has arrived. The check is
  // made at the falling edge, once the driver's updates at the rising edge have settled.
  task automatic wait_drained();
    while (pending_pages.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Stimulus: a directed run over the replacement cases, then random chunks.
  initial begin : stimulus
    logic [PAGE_FIELD_W-1:0] pool [8];
    int unsigned             pool_n;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fills, a hit on the newest and the oldest frame, evictions of the true oldest,
    // repeated references and single-bit pages. The saturated fault count would need
    // four thousand million misses and is out of reach.
    idle_on = 1'b1;
    pending_pages = '{16'h0000, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'hAAAA,
                      16'hFFFF, 16'h1234, 16'h0000, 16'h5555, 16'h8001, 16'h8001,
                      16'h0001, 16'h0100, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001,
                      16'h7FFF, 16'h8000, 16'h2468, 16'hFFFF};
    // The sender pauses here until the row has answered everything.
    wait_drained();

    for (int c = 0; c < CHUNKS; c++) begin
      idle_on = (c == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      // A small working set gives hits, a larger one forces evictions.
      pool_n = $urandom_range(3, 8);
      for (int p = 0; p < 8; p++) pool[p] = PAGE_FIELD_W'($urandom_range(0, 16'hFFFF));
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 85)
          pending_pages.push_back(pool[$urandom_range(0, pool_n - 1)]);
        else
          pending_pages.push_back(PAGE_FIELD_W'($urandom_range(0, 16'hFFFF)));
      end
      if (c == 3) long_hold_go = 1'b1;
      while (pending_pages.size() != 0) @(posedge clk_i);
    end

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("lru_page_replacement_tb: done, clean");
    end else begin
      $display("lru_page_replacement_tb: done, errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(20_000_000);
    $display("lru_page_replacement_tb: done, errors");
    $finish;
  end

endmodule
